// ----- src/kst_pkg.sv -----
// kst_pkg: operation and status codes of the keyed slot table
// no dependencies; used by the channel interfaces and the top level
package kst_pkg;

   typedef logic [1:0] op_type;
   typedef logic [1:0] status_type;

   localparam op_type OP_LOOKUP  = 2'd0;
   localparam op_type OP_INSERT  = 2'd1;
   localparam op_type OP_ERASE   = 2'd2;
   localparam op_type OP_COMPACT = 2'd3;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NOT_FOUND = 2'd1;
   localparam status_type ST_FULL      = 2'd2;

   localparam int KEY_W  = 32;
   localparam int VAL_W  = 32;
   localparam int ULEN_W = 5;

endpackage

// ----- src/kst_req_if.sv -----
// kst_req_if: request channel of the keyed slot table (valid/ready plus payload)
// depends on kst_pkg
interface kst_req_if;
   logic                               valid;
   logic                               ready;
   kst_pkg::op_type                    op;
   logic signed [kst_pkg::KEY_W-1:0]   req_key;
   logic        [kst_pkg::VAL_W-1:0]   req_value;

   modport source (output valid, output op, output req_key, output req_value, input ready);
   modport sink   (input valid, input op, input req_key, input req_value, output ready);
endinterface

// ----- src/kst_rsp_if.sv -----
// kst_rsp_if: response channel of the keyed slot table (valid/ready plus payload)
// depends on kst_pkg
interface kst_rsp_if;
   logic                          valid;
   logic                          ready;
   kst_pkg::status_type           status;
   logic [kst_pkg::VAL_W-1:0]     found_value;
   logic [kst_pkg::ULEN_W-1:0]    used_length;

   modport source (output valid, output status, output found_value, output used_length,
                   input ready);
   modport sink   (input valid, input status, input found_value, input used_length,
                   output ready);
endinterface

// ----- src/keyed_slot_table.sv -----
// Keyed slot table: ENTRIES slots of {busy, key, value} held in one memory with a
// single registered read port, scanned one slot per cycle in order. A request
// (lookup, insert, erase, compact) is accepted in the idle state, scans its slots
// and then waits in the post state until the output register can take its result.
// Lookup and erase stop at the first busy match and insert at the first free slot
// below the used length. Compact always walks the whole used length. The response
// becomes valid in the same cycle as the next request can be taken. The scan speed
// is set by the one read port of the slot memory; compact writes its moved entries
// through the write port in the same cycles. Only slots below the used length are
// ever read, so reset just clears the used length and no clearing pass is needed.
// One request is worked on at a time; the next one is accepted while the previous
// response still waits in the output register.
// depends on kst_pkg, kst_req_if, kst_rsp_if
module keyed_slot_table #(
   parameter int ENTRIES = 16
) (
   input  logic       clock,
   input  logic       reset,
   kst_req_if.sink    req_bus,
   kst_rsp_if.source  rsp_bus
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_POST = 2'd2;

   typedef struct packed {
      logic                          busy;
      logic [kst_pkg::KEY_W-1:0]     key;
      logic [kst_pkg::VAL_W-1:0]     value;
   } entry_type;

   // slot memory
   entry_type         slot_mem [ENTRIES];
   entry_type         rdata_ff;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   entry_type         mem_wdata;

   // control and working registers
   logic [1:0]                  state_ff, state_in;
   kst_pkg::op_type             op_ff, op_in;
   logic [kst_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [kst_pkg::VAL_W-1:0]   val_ff, val_in;
   logic [CW-1:0]               rd_ptr_ff, rd_ptr_in;
   logic                        pend_ff, pend_in;
   logic [AW-1:0]               pend_idx_ff, pend_idx_in;
   logic [CW-1:0]               wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]               used_len_ff, used_len_in;
   kst_pkg::status_type         res_status_ff, res_status_in;
   logic [kst_pkg::VAL_W-1:0]   res_found_ff, res_found_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   kst_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [kst_pkg::VAL_W-1:0]   rsp_found_ff, rsp_found_in;
   logic [kst_pkg::ULEN_W-1:0]  rsp_len_ff, rsp_len_in;

   logic                        issue;
   logic                        key_hit;
   logic [31:0]                 len_ext;

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.found_value = rsp_found_ff;
   assign rsp_bus.used_length = rsp_len_ff;

   assign issue     = (state_ff == S_SCAN) && (rd_ptr_ff < used_len_ff);
   assign key_hit   = pend_ff && rdata_ff.busy && (rdata_ff.key == key_ff);
   assign len_ext   = 32'(used_len_ff);
   assign mem_re    = issue;
   assign mem_raddr = rd_ptr_ff[AW-1:0];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      rd_ptr_in     = rd_ptr_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      wr_ptr_in     = wr_ptr_ff;
      used_len_in   = used_len_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      mem_we        = 1'b0;
      mem_waddr     = pend_idx_ff;
      mem_wdata     = '{busy: 1'b1, key: key_ff, value: val_ff};

      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_len_in    = rsp_len_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in     = req_bus.op;
               key_in    = req_bus.req_key;
               val_in    = req_bus.req_value;
               rd_ptr_in = '0;
               wr_ptr_in = '0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            // one slot read issued per cycle, the previous one evaluated
            pend_in     = issue;
            pend_idx_in = rd_ptr_ff[AW-1:0];
            if (issue) begin
               rd_ptr_in = rd_ptr_ff + CW'(1);
            end
            res_status_in = kst_pkg::ST_OK;
            res_found_in  = '0;
            unique case (op_ff)
               kst_pkg::OP_LOOKUP: begin
                  if (key_hit) begin
                     res_found_in = rdata_ff.value;
                     state_in     = S_POST;
                  end else if (!pend_ff && !issue) begin
                     res_status_in = kst_pkg::ST_NOT_FOUND;
                     state_in      = S_POST;
                  end
               end
               kst_pkg::OP_ERASE: begin
                  if (key_hit) begin
                     mem_we         = 1'b1;
                     mem_wdata.busy = 1'b0;
                     state_in       = S_POST;
                  end else if (!pend_ff && !issue) begin
                     res_status_in = kst_pkg::ST_NOT_FOUND;
                     state_in      = S_POST;
                  end
               end
               kst_pkg::OP_INSERT: begin
                  if (pend_ff && !rdata_ff.busy) begin
                     // reuse first free slot below the used length
                     mem_we   = 1'b1;
                     state_in = S_POST;
                  end else if (!pend_ff && !issue) begin
                     if (used_len_ff < CW'(ENTRIES)) begin
                        // append at the end
                        mem_we      = 1'b1;
                        mem_waddr   = used_len_ff[AW-1:0];
                        used_len_in = used_len_ff + CW'(1);
                     end else begin
                        res_status_in = kst_pkg::ST_FULL;
                     end
                     state_in = S_POST;
                  end
               end
               kst_pkg::OP_COMPACT: begin
                  if (pend_ff && rdata_ff.busy) begin
                     // move busy entry down to the next packed position
                     mem_we    = 1'b1;
                     mem_waddr = wr_ptr_ff[AW-1:0];
                     mem_wdata = rdata_ff;
                     wr_ptr_in = wr_ptr_ff + CW'(1);
                  end else if (!pend_ff && !issue) begin
                     used_len_in = wr_ptr_ff;
                     state_in    = S_POST;
                  end
               end
               default: begin
                  state_in = S_POST;
               end
            endcase
            if (state_in == S_POST) begin
               pend_in = 1'b0;
            end
         end
         S_POST: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_len_in    = len_ext[kst_pkg::ULEN_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // slot memory ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= slot_mem[mem_raddr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         used_len_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         used_len_ff  <= used_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      rd_ptr_ff     <= rd_ptr_in;
      pend_idx_ff   <= pend_idx_in;
      wr_ptr_ff     <= wr_ptr_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_len_ff    <= rsp_len_in;
   end

endmodule
